@@ src/hpvt_pkg.sv @@
// ----------------------------------------------------------------------------
// hpvt_pkg
// Shared types, constants and arithmetic helpers of the homogeneous
// point/vector transform core.
// ----------------------------------------------------------------------------
package hpvt_pkg;

	localparam int unsigned N_PAIRS   = 8;
	localparam int unsigned N_ROWS    = 4;
	localparam int unsigned N_LANES   = 3;
	localparam int unsigned FRAC_W    = 16;
	localparam int unsigned ACC_W     = 66;
	localparam int unsigned RES_W     = 50;
	localparam int unsigned DIV_STEPS = 32;
	localparam int unsigned Q_DEPTH   = 4;
	localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);

	typedef logic signed [31:0]      q16_t;
	typedef logic [63:0]             pair_t;
	typedef logic signed [RES_W-1:0] res_t;
	typedef logic [RES_W-1:0]        mag_t;

	localparam q16_t ONE_Q16  = 32'sh0001_0000;
	localparam q16_t ZERO_Q16 = 32'sh0000_0000;
	localparam q16_t Q16_MAX  = 32'sh7FFF_FFFF;
	localparam q16_t Q16_MIN  = 32'sh8000_0000;

	localparam pair_t PAIR_RESET [N_PAIRS] = '{
		64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
		64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
	};

	typedef struct packed {
		logic point;
		res_t x;
		res_t y;
		res_t z;
		res_t w;
	} row_item_t;

	typedef struct packed {
		mag_t        rem;
		logic [31:0] qd;
		logic        neg;
		logic        sat;
	} lane_t;

	typedef struct packed {
		logic point;
		logic zero_w;
		mag_t ud;
	} div_meta_t;

	function automatic mag_t abs_res(input res_t v);
		res_t n;
		begin
			n = -v;
			abs_res = v[RES_W-1] ? mag_t'(n) : mag_t'(v);
		end
	endfunction

	function automatic q16_t sat_res(input res_t v);
		begin
			if (v > res_t'(Q16_MAX))
				sat_res = Q16_MAX;
			else if (v < res_t'(Q16_MIN))
				sat_res = Q16_MIN;
			else
				sat_res = v[31:0];
		end
	endfunction

	function automatic lane_t div_step(input lane_t l, input mag_t ud, input logic point);
		logic [RES_W:0] t;
		logic [RES_W:0] diff;
		logic           ge;
		lane_t          o;
		begin
			t    = {l.rem, l.qd[31]};
			diff = t - {1'b0, ud};
			ge   = (t >= {1'b0, ud});
			o    = l;
			if (point) begin
				o.rem = ge ? diff[RES_W-1:0] : t[RES_W-1:0];
				o.qd  = {l.qd[30:0], ge};
			end
			div_step = o;
		end
	endfunction

	function automatic q16_t div_finish(input lane_t l);
		logic [32:0] mag;
		logic [32:0] neg_mag;
		begin
			mag     = l.sat ? 33'h1_0000_0000 : {1'b0, l.qd};
			neg_mag = -mag;
			if (l.neg)
				div_finish = (mag > 33'h0_8000_0000) ? Q16_MIN : neg_mag[31:0];
			else
				div_finish = (mag > 33'h0_7FFF_FFFF) ? Q16_MAX : mag[31:0];
		end
	endfunction

endpackage

@@ src/hpvt_front.sv @@
// ----------------------------------------------------------------------------
// hpvt_front
// Accepts words, multiplies by the matrix and forms the rounded row sums.
// ----------------------------------------------------------------------------
module hpvt_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  kind,
	input  hpvt_pkg::q16_t        in_x,
	input  hpvt_pkg::q16_t        in_y,
	input  hpvt_pkg::q16_t        in_z,
	input  hpvt_pkg::pair_t       matrix [hpvt_pkg::N_PAIRS],
	input  logic                  q_full,
	output logic                  push,
	output hpvt_pkg::row_item_t   push_item
);

	hpvt_pkg::q16_t       ent [hpvt_pkg::N_ROWS][4];
	hpvt_pkg::q16_t       vec [4];
	logic signed [63:0]   prod_s1 [hpvt_pkg::N_ROWS][4];
	logic signed [64:0]   half_s2 [hpvt_pkg::N_ROWS][2];
	hpvt_pkg::res_t       res_s3  [hpvt_pkg::N_ROWS];
	logic                 valid_s1, valid_s2, valid_s3;
	logic                 point_s1, point_s2, point_s3;
	logic                 en;

	assign en       = !(valid_s3 && q_full);
	assign in_ready = en;
	assign push     = valid_s3 && !q_full;

	assign vec[0] = in_x;
	assign vec[1] = in_y;
	assign vec[2] = in_z;
	assign vec[3] = kind ? hpvt_pkg::ONE_Q16 : hpvt_pkg::ZERO_Q16;

	for (genvar r = 0; r < hpvt_pkg::N_ROWS; r++) begin : g_row
		for (genvar c = 0; c < 4; c++) begin : g_col
			assign ent[r][c] = matrix[r*2 + c/2][32*(c%2) +: 32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			point_s1 <= kind;
			point_s2 <= point_s1;
			point_s3 <= point_s2;
			for (int r = 0; r < hpvt_pkg::N_ROWS; r++) begin
				for (int c = 0; c < 4; c++)
					prod_s1[r][c] <= ent[r][c] * vec[c];
				half_s2[r][0] <= 65'(prod_s1[r][0]) + 65'(prod_s1[r][1]);
				half_s2[r][1] <= 65'(prod_s1[r][2]) + 65'(prod_s1[r][3]);
			end
		end
	end

	always_ff @(posedge clk) begin
		logic signed [hpvt_pkg::ACC_W-1:0] tot;
		if (en) begin
			for (int r = 0; r < hpvt_pkg::N_ROWS; r++) begin
				tot = hpvt_pkg::ACC_W'(half_s2[r][0]) + hpvt_pkg::ACC_W'(half_s2[r][1])
					+ hpvt_pkg::ACC_W'(32768);
				res_s3[r] <= tot[hpvt_pkg::ACC_W-1:hpvt_pkg::FRAC_W];
			end
		end
	end

	assign push_item.point = point_s3;
	assign push_item.x     = res_s3[0];
	assign push_item.y     = res_s3[1];
	assign push_item.z     = res_s3[2];
	assign push_item.w     = res_s3[3];

endmodule

@@ src/hpvt_fifo.sv @@
// ----------------------------------------------------------------------------
// hpvt_fifo
// Short queue of row sums between front and back.
// ----------------------------------------------------------------------------
module hpvt_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  hpvt_pkg::row_item_t  push_item,
	output logic                 full,
	input  logic                 pop,
	output hpvt_pkg::row_item_t  pop_item,
	output logic                 empty
);

	hpvt_pkg::row_item_t                  mem [hpvt_pkg::Q_DEPTH];
	logic [hpvt_pkg::Q_PTR_W-1:0]         wr_ptr_q, rd_ptr_q;
	logic [hpvt_pkg::Q_CNT_W-1:0]         cnt_q;

	assign full     = (cnt_q == hpvt_pkg::Q_CNT_W'(hpvt_pkg::Q_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_item = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_item;
	end

endmodule

@@ src/hpvt_back.sv @@
// ----------------------------------------------------------------------------
// hpvt_back
// Perspective divide pipeline, one quotient bit per stage, and output word.
// ----------------------------------------------------------------------------
module hpvt_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  hpvt_pkg::row_item_t  q_item,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output hpvt_pkg::q16_t       out_x,
	output hpvt_pkg::q16_t       out_y,
	output hpvt_pkg::q16_t       out_z,
	output logic                 divide_error
);

	localparam int unsigned NS = hpvt_pkg::DIV_STEPS;

	hpvt_pkg::lane_t     lane_s [NS+1][hpvt_pkg::N_LANES];
	hpvt_pkg::div_meta_t meta_s [NS+1];
	logic                valid_s [NS+1];
	hpvt_pkg::res_t      num [hpvt_pkg::N_LANES];
	hpvt_pkg::lane_t     prep [hpvt_pkg::N_LANES];
	hpvt_pkg::div_meta_t prep_meta;
	hpvt_pkg::q16_t      res_q [hpvt_pkg::N_LANES];
	logic                err_q;
	logic                out_valid_q;
	logic                adv;

	assign adv = !out_valid_q || out_ready;
	assign pop = adv && !q_empty;

	assign num[0] = q_item.x;
	assign num[1] = q_item.y;
	assign num[2] = q_item.z;

	always_comb begin
		hpvt_pkg::mag_t un;
		prep_meta.point  = q_item.point;
		prep_meta.zero_w = (q_item.w == '0);
		prep_meta.ud     = hpvt_pkg::abs_res(q_item.w);
		for (int l = 0; l < hpvt_pkg::N_LANES; l++) begin
			un           = hpvt_pkg::abs_res(num[l]);
			prep[l].neg  = num[l][hpvt_pkg::RES_W-1] ^ q_item.w[hpvt_pkg::RES_W-1];
			prep[l].sat  = ((un >> hpvt_pkg::FRAC_W) >= prep_meta.ud);
			prep[l].rem  = un >> hpvt_pkg::FRAC_W;
			prep[l].qd   = q_item.point ? {un[15:0], 16'h0000} : hpvt_pkg::sat_res(num[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NS; k++)
				valid_s[k] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s[0] <= !q_empty;
			for (int k = 0; k < NS; k++)
				valid_s[k+1] <= valid_s[k];
			out_valid_q <= valid_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s[0] <= prep_meta;
			for (int l = 0; l < hpvt_pkg::N_LANES; l++)
				lane_s[0][l] <= prep[l];
			for (int k = 0; k < NS; k++) begin
				meta_s[k+1] <= meta_s[k];
				for (int l = 0; l < hpvt_pkg::N_LANES; l++)
					lane_s[k+1][l] <= hpvt_pkg::div_step(lane_s[k][l], meta_s[k].ud,
						meta_s[k].point);
			end
			err_q <= meta_s[NS].point && meta_s[NS].zero_w;
			for (int l = 0; l < hpvt_pkg::N_LANES; l++) begin
				if (!meta_s[NS].point)
					res_q[l] <= lane_s[NS][l].qd;
				else if (meta_s[NS].zero_w)
					res_q[l] <= hpvt_pkg::ZERO_Q16;
				else
					res_q[l] <= hpvt_pkg::div_finish(lane_s[NS][l]);
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_x        = res_q[0];
	assign out_y        = res_q[1];
	assign out_z        = res_q[2];
	assign divide_error = err_q;

endmodule

@@ src/homogeneous_point_vector_transform_core.sv @@
// ----------------------------------------------------------------------------
// homogeneous_point_vector_transform_core
// 4x4 homogeneous transform of Q16.16 points and directions.
// ----------------------------------------------------------------------------
// One word in and one word out per clock in steady flow. A word passes the
// product, half-sum and row-sum registers of the multiply/sum front, then a
// four-entry queue, then the back: one prepare stage, 32 divide stages (one
// quotient bit each, three lanes side by side) and the output register.
// Directions skip the divide arithmetic but follow the same path, so order
// is kept. The matrix sits in eight 64-bit registers at byte address 8*i,
// reset to identity; write it only while the core is idle.
// ----------------------------------------------------------------------------
module homogeneous_point_vector_transform_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [5:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,   // in_x, in_y, in_z
	input  logic         s_tuser,   // kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,   // out_x, out_y, out_z
	output logic         m_tuser    // divide_error
);

	hpvt_pkg::pair_t     matrix_q [hpvt_pkg::N_PAIRS];
	hpvt_pkg::row_item_t push_item, pop_item;
	logic                push, pop, q_full, q_empty;
	hpvt_pkg::q16_t      out_x, out_y, out_z;

	assign pready = 1'b1;
	assign prdata = matrix_q[paddr[5:3]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hpvt_pkg::N_PAIRS; i++)
				matrix_q[i] <= hpvt_pkg::PAIR_RESET[i];
		end else if (psel && penable && pwrite && pready) begin
			matrix_q[paddr[5:3]] <= pwdata;
		end
	end

	hpvt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.kind      (s_tuser),
		.in_x      (s_tdata[31:0]),
		.in_y      (s_tdata[63:32]),
		.in_z      (s_tdata[95:64]),
		.matrix    (matrix_q),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	hpvt_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (q_empty)
	);

	hpvt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_item       (pop_item),
		.pop          (pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_z        (out_z),
		.divide_error (m_tuser)
	);

	assign m_tdata = {out_z, out_y, out_x};

endmodule
